@@ hw/rtl/trp_pkg.sv @@
// Shared types and constants for the timed relay command parser.
`default_nettype none

package trp_pkg;

	localparam int TIME_BITS = 16;

	// Width that holds both the countdown and the 16-bit status field.
	localparam int SEC_EXT_BITS = (TIME_BITS > 16) ? TIME_BITS : 16;

	localparam int SECONDS_BITS = 16;

	typedef enum logic [3:0] {
		PH_START,
		PH_O,
		PH_ON,
		PH_OF,
		PH_OFF,
		PH_DIGITS,
		PH_SEC,
		PH_MIN,
		PH_BAD,
		PH_EXACT_ON,
		PH_EXACT_OFF
	} phase_t;

	// Verdict on a command whose last word is being accepted.
	typedef struct packed {
		logic                 exact;
		logic                 timed;
		logic                 target;
		logic [TIME_BITS-1:0] time_val;
	} parse_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/trp_parse.sv @@
// Command text parser: tracks the phase, the target level and the time value.
`default_nettype none

module trp_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  byte_en,
	input  wire [7:0]            char_byte,
	input  wire                  last_byte,
	output trp_pkg::parse_res_t  res
);

	localparam int TB    = trp_pkg::TIME_BITS;
	localparam int ACC_W = trp_pkg::TIME_BITS + 6;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_M     = 8'h6D;

	localparam logic [ACC_W-1:0] TIME_MAX_EXT = ACC_W'({TB{1'b1}});

	trp_pkg::phase_t phase_q;
	trp_pkg::phase_t phase_mid;
	trp_pkg::phase_t phase_end;
	trp_pkg::phase_t phase_d;
	logic            target_q;
	logic            target_d;
	logic [TB-1:0]   accum_q;
	logic [TB-1:0]   accum_mid;
	logic [TB-1:0]   accum_d;
	logic [ACC_W-1:0] accum_ext;
	logic [ACC_W-1:0] mul10;
	logic [ACC_W-1:0] mul60;
	logic             is_digit;

	function automatic trp_pkg::phase_t next_phase(input trp_pkg::phase_t ph,
			input logic [7:0] c);
		trp_pkg::phase_t nx;
		nx = ph;
		case (ph)
			trp_pkg::PH_START: nx = (c == CH_O) ? trp_pkg::PH_O : trp_pkg::PH_BAD;
			trp_pkg::PH_O: begin
				if (c == CH_N)
					nx = trp_pkg::PH_ON;
				else if (c == CH_F)
					nx = trp_pkg::PH_OF;
				else
					nx = trp_pkg::PH_BAD;
			end
			trp_pkg::PH_OF: nx = (c == CH_F) ? trp_pkg::PH_OFF : trp_pkg::PH_BAD;
			trp_pkg::PH_ON, trp_pkg::PH_OFF: begin
				if (c == CH_NUL)
					nx = (ph == trp_pkg::PH_ON) ? trp_pkg::PH_EXACT_ON
						: trp_pkg::PH_EXACT_OFF;
				else if (c == CH_COMMA)
					nx = trp_pkg::PH_DIGITS;
				else
					nx = trp_pkg::PH_BAD;
			end
			trp_pkg::PH_DIGITS: begin
				if (c >= CH_ZERO && c <= CH_NINE)
					nx = trp_pkg::PH_DIGITS;
				else if (c == CH_S)
					nx = trp_pkg::PH_SEC;
				else if (c == CH_M)
					nx = trp_pkg::PH_MIN;
				else
					nx = trp_pkg::PH_BAD;
			end
			trp_pkg::PH_SEC, trp_pkg::PH_MIN, trp_pkg::PH_BAD,
			trp_pkg::PH_EXACT_ON, trp_pkg::PH_EXACT_OFF: nx = ph;
			default: nx = trp_pkg::PH_BAD;
		endcase
		return nx;
	endfunction

	// The end of text acts as one more NUL fed after the last word.
	always_comb begin
		phase_mid = next_phase(phase_q, char_byte);
		phase_end = next_phase(phase_mid, CH_NUL);
		if (!byte_en)
			phase_d = phase_q;
		else if (last_byte)
			phase_d = trp_pkg::PH_START;
		else
			phase_d = phase_mid;
	end

	// Time arithmetic only happens on the real character; the NUL never
	// touches the value.
	always_comb begin
		is_digit  = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
		accum_ext = ACC_W'(accum_q);
		mul10     = (accum_ext << 3) + (accum_ext << 1) + ACC_W'(char_byte[3:0]);
		mul60     = (accum_ext << 6) - (accum_ext << 2);
		accum_mid = accum_q;
		target_d  = target_q;
		case (phase_q)
			trp_pkg::PH_O: begin
				if (char_byte == CH_N)
					target_d = 1'b1;
				else if (char_byte == CH_F)
					target_d = 1'b0;
			end
			trp_pkg::PH_ON, trp_pkg::PH_OFF: begin
				if (char_byte == CH_COMMA)
					accum_mid = '0;
			end
			trp_pkg::PH_DIGITS: begin
				if (is_digit)
					accum_mid = (mul10 > TIME_MAX_EXT) ? {TB{1'b1}} : mul10[TB-1:0];
				else if (char_byte == CH_M)
					accum_mid = (mul60 > TIME_MAX_EXT) ? {TB{1'b1}} : mul60[TB-1:0];
			end
			default: accum_mid = accum_q;
		endcase
		if (!byte_en) begin
			accum_d  = accum_q;
			target_d = target_q;
		end else if (last_byte) begin
			accum_d = '0;
		end else begin
			accum_d = accum_mid;
		end
	end

	always_comb begin
		res.exact    = (phase_end == trp_pkg::PH_EXACT_ON)
			|| (phase_end == trp_pkg::PH_EXACT_OFF);
		res.timed    = ((phase_end == trp_pkg::PH_SEC) || (phase_end == trp_pkg::PH_MIN))
			&& (accum_mid != '0);
		res.target   = target_d;
		res.time_val = accum_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= trp_pkg::PH_START;
			target_q <= 1'b0;
			accum_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			target_q <= target_d;
			accum_q  <= accum_d;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/timed_relay_command_parser.sv @@
// The result word for an item is on the outputs in the cycle after it is accepted.
// Throughput: one word per cycle unless the output stalls; the output register lets a new word in while
// the previous result is taken in the same cycle.
// All per-item work is one pass through the parser and relay update logic.
// Reset: relay off, no countdown, parser at the start of a command, no result held.
`default_nettype none

module timed_relay_command_parser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         req_type,
	input  wire  [7:0]  char_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        relay_on,
	output logic [15:0] seconds_left,
	output logic        command_done,
	output logic        command_error
);

	localparam int TB = trp_pkg::TIME_BITS;
	localparam int CW = trp_pkg::SEC_EXT_BITS;
	localparam int SB = trp_pkg::SECONDS_BITS;

	logic                in_acc;
	logic                byte_en;
	trp_pkg::parse_res_t pres;

	logic          relay_q;
	logic          restore_q;
	logic [TB-1:0] countdown_q;
	logic          relay_d;
	logic          restore_d;
	logic [TB-1:0] countdown_d;
	logic [TB-1:0] cd_dec;
	logic          done_d;
	logic          err_d;
	logic [CW-1:0] cd_ext;

	assign in_ready = !out_valid || out_ready;
	assign in_acc   = in_valid && in_ready;
	assign byte_en  = in_acc && !req_type;

	trp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_en   (byte_en),
		.char_byte (char_byte),
		.last_byte (last_byte),
		.res       (pres)
	);

	always_comb begin
		relay_d     = relay_q;
		restore_d   = restore_q;
		countdown_d = countdown_q;
		done_d      = 1'b0;
		err_d       = 1'b0;
		cd_dec      = countdown_q - TB'(1);
		if (req_type) begin
			if (countdown_q != '0) begin
				countdown_d = cd_dec;
				if (cd_dec == '0)
					relay_d = restore_q;
			end
		end else if (last_byte) begin
			done_d = 1'b1;
			if (pres.exact) begin
				relay_d     = pres.target;
				countdown_d = '0;
			end else if (pres.timed) begin
				restore_d   = relay_q;
				relay_d     = pres.target;
				countdown_d = pres.time_val;
			end else begin
				err_d = 1'b1;
			end
		end
		cd_ext = CW'(countdown_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relay_q     <= 1'b0;
			restore_q   <= 1'b0;
			countdown_q <= '0;
		end else if (in_acc) begin
			relay_q     <= relay_d;
			restore_q   <= restore_d;
			countdown_q <= countdown_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (in_acc)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			relay_on      <= relay_d;
			seconds_left  <= (cd_ext > CW'({SB{1'b1}})) ? {SB{1'b1}} : cd_ext[SB-1:0];
			command_done  <= done_d;
			command_error <= err_d;
		end
	end

	a_err_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_error |-> command_done)
		else $error("error flag without a completed command");

	a_tick_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type |=> !command_done && !command_error)
		else $error("tick word reported a command");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type && countdown_q == '0 |=> $stable(relay_q) && countdown_q == '0)
		else $error("tick with no countdown changed the relay");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid && relay_on == relay_q)
		else $error("result word missing or relay mismatch");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking testbench for the timed relay command parser: directed table, then random commands.
module tb;

	typedef struct packed {
		logic        relay;
		logic [15:0] secs;
		logic        done;
		logic        err;
	} status_t;

	typedef struct {
		logic       tick;
		logic [7:0] c;
		logic       last;
		logic       typed;
		status_t    want;
	} row_t;

	localparam int RANDOM_WORDS = 1500;
	localparam int HOLD_AT = 600;
	localparam int HOLD_CYCLES = 400;
	localparam int TB_W = trp_pkg::TIME_BITS;
	localparam logic [TB_W-1:0] TIME_MAX = '1;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       req_type = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       relay_on;
	logic [15:0] seconds_left;
	logic       command_done;
	logic       command_error;

	// Predictor state, mirrors what the block keeps.
	logic              relay_lvl = 1'b0;
	logic              saved_lvl = 1'b0;
	logic              target_lvl = 1'b0;
	logic [TB_W-1:0]   countdown = '0;
	logic [TB_W-1:0]   accum = '0;
	trp_pkg::phase_t   phase = trp_pkg::PH_START;

	status_t status_due[$];
	row_t    directed_rows[$];

	int n_sent = 0;
	int n_results = 0;
	int n_errors = 0;
	int n_ticks = 0;
	int n_commands = 0;
	int n_rejected = 0;
	int n_expired = 0;

	timed_relay_command_parser i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.char_byte     (char_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.relay_on      (relay_on),
		.seconds_left  (seconds_left),
		.command_done  (command_done),
		.command_error (command_error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3000000;
		$display("timed_relay_command_parser: mismatch");
		$finish;
	end

	function automatic void feed_char(input logic [7:0] c);
		logic [TB_W+7:0] v;
		case (phase)
			trp_pkg::PH_START: phase = (c == "o") ? trp_pkg::PH_O : trp_pkg::PH_BAD;
			trp_pkg::PH_O: begin
				if (c == "n") begin
					phase = trp_pkg::PH_ON;
					target_lvl = 1'b1;
				end else if (c == "f") begin
					phase = trp_pkg::PH_OF;
					target_lvl = 1'b0;
				end else
					phase = trp_pkg::PH_BAD;
			end
			trp_pkg::PH_OF: phase = (c == "f") ? trp_pkg::PH_OFF : trp_pkg::PH_BAD;
			trp_pkg::PH_ON, trp_pkg::PH_OFF: begin
				if (c == 8'h00)
					phase = (phase == trp_pkg::PH_ON) ? trp_pkg::PH_EXACT_ON
						: trp_pkg::PH_EXACT_OFF;
				else if (c == ",") begin
					phase = trp_pkg::PH_DIGITS;
					accum = '0;
				end else
					phase = trp_pkg::PH_BAD;
			end
			trp_pkg::PH_DIGITS: begin
				if (c >= "0" && c <= "9") begin
					v = (TB_W+8)'(accum * 10 + (c - "0"));
					accum = (v > TIME_MAX) ? TIME_MAX : v[TB_W-1:0];
				end else if (c == "s")
					phase = trp_pkg::PH_SEC;
				else if (c == "m") begin
					v = (TB_W+8)'(accum * 60);
					accum = (v > TIME_MAX) ? TIME_MAX : v[TB_W-1:0];
					phase = trp_pkg::PH_MIN;
				end else
					phase = trp_pkg::PH_BAD;
			end
			trp_pkg::PH_SEC, trp_pkg::PH_MIN, trp_pkg::PH_BAD,
			trp_pkg::PH_EXACT_ON, trp_pkg::PH_EXACT_OFF: ;
			default: phase = trp_pkg::PH_BAD;
		endcase
	endfunction

	// Expected relay status after one word, updating the predictor state.
	function automatic status_t relay_next(input logic tick, input logic [7:0] c,
			input logic last);
		status_t s;
		s = '0;
		if (tick) begin
			n_ticks++;
			if (countdown != 0) begin
				countdown = countdown - 1'b1;
				if (countdown == 0) begin
					relay_lvl = saved_lvl;
					n_expired++;
				end
			end
		end else begin
			feed_char(c);
			if (last) begin
				// The end of the text counts as a NUL.
				feed_char(8'h00);
				s.done = 1'b1;
				n_commands++;
				if (phase == trp_pkg::PH_EXACT_ON || phase == trp_pkg::PH_EXACT_OFF) begin
					relay_lvl = target_lvl;
					countdown = '0;
				end else if ((phase == trp_pkg::PH_SEC || phase == trp_pkg::PH_MIN)
						&& accum != 0) begin
					saved_lvl = relay_lvl;
					relay_lvl = target_lvl;
					countdown = accum;
				end else begin
					s.err = 1'b1;
					n_rejected++;
				end
				phase = trp_pkg::PH_START;
				accum = '0;
			end
		end
		s.relay = relay_lvl;
		s.secs = (countdown > 16'hFFFF) ? 16'hFFFF : 16'(countdown);
		return s;
	endfunction

	// Runs of zero gaps alternate with random gaps.
	function automatic int pick_gap(input int n, input int span);
		return ((n / span) % 4 == 3) ? 0 : $urandom_range(0, 17);
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (n_errors < 40)
			$display("result %0d: %s is %0d, expected %0d", n_results, field, got, want);
		n_errors++;
	endtask

	task automatic send_word(input logic tick, input logic [7:0] c, input logic last,
			input logic typed = 1'b0, input status_t want = '0);
		int gap;
		logic took;
		status_t predicted;
		gap = pick_gap(n_sent, 97);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= tick;
		char_byte <= c;
		last_byte <= last;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		predicted = relay_next(tick, c, last);
		status_due.push_back(typed ? want : predicted);
		n_sent++;
	endtask

	task automatic send_tick();
		send_word(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	task automatic add_row(input logic tick, input logic [7:0] c, input logic last,
			input logic typed = 1'b0, input status_t want = '0);
		row_t r;
		r.tick = tick;
		r.c = c;
		r.last = last;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endtask

	// Mostly well-formed commands with random content; some broken, some noise.
	task automatic send_random_command();
		logic [7:0] txt[$];
		logic [7:0] sfx;
		int r, sel, ndig, pos;
		logic broken, cut;
		r = $urandom_range(0, 99);
		broken = (r >= 75 && r < 92);
		cut = broken && ($urandom_range(0, 1) == 1);
		txt.push_back("o");
		if ($urandom_range(0, 1))
			txt.push_back("n");
		else begin
			txt.push_back("f");
			txt.push_back("f");
		end
		if (r < 15) begin
			if ($urandom_range(0, 1)) begin
				txt.push_back(8'h00);
				repeat ($urandom_range(0, 3)) txt.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			txt.push_back(",");
			sel = $urandom_range(0, 9);
			ndig = (sel < 7) ? 1 : (sel < 9) ? 3 : 6;
			repeat (ndig) txt.push_back(8'("0" + $urandom_range(0, 9)));
			sfx = ($urandom_range(0, 3) == 0) ? "m" : "s";
			if (!cut) begin
				txt.push_back(sfx);
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 3)) txt.push_back(8'($urandom_range(0, 255)));
			end
			if (broken && !cut) begin
				pos = $urandom_range(0, txt.size() - 1);
				txt[pos] = 8'($urandom_range(0, 255));
			end
		end
		if (r >= 92) begin
			txt.delete();
			repeat ($urandom_range(1, 4)) txt.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < txt.size(); i++) begin
			if ($urandom_range(0, 4) == 0)
				send_tick();
			send_word(1'b0, txt[i], i == txt.size() - 1);
		end
		repeat ($urandom_range(0, 4)) send_tick();
	endtask

	initial begin : drain
		int gap;
		logic seen;
		status_t got;
		status_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// One long hold-off lets the block fill up and stall its input.
			gap = (n_results == HOLD_AT) ? HOLD_CYCLES : pick_gap(n_results, 131);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				seen = out_valid;
				got = {relay_on, seconds_left, command_done, command_error};
				@(posedge clk);
			end while (!seen);
			n_results++;
			if (status_due.size() == 0)
				report_mismatch("result word with nothing pending", 1, 0);
			else begin
				want = status_due.pop_front();
				if (got.relay !== want.relay)
					report_mismatch("relay_on", got.relay, want.relay);
				if (got.secs !== want.secs)
					report_mismatch("seconds_left", got.secs, want.secs);
				if (got.done !== want.done)
					report_mismatch("command_done", got.done, want.done);
				if (got.err !== want.err)
					report_mismatch("command_error", got.err, want.err);
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A tick with no timeout running changes nothing.
		add_row(1'b1, 8'h00, 1'b0, 1'b1, {1'b0, 16'd0, 1'b0, 1'b0});
		add_row(1'b0, "o", 1'b0);
		add_row(1'b0, "n", 1'b1, 1'b1, {1'b1, 16'd0, 1'b1, 1'b0});
		// Exact off, closed by a NUL on the last word.
		add_row(1'b0, "o", 1'b0);
		add_row(1'b0, "f", 1'b0);
		add_row(1'b0, "f", 1'b0);
		add_row(1'b0, 8'h00, 1'b1, 1'b1, {1'b0, 16'd0, 1'b1, 1'b0});
		// A zero time is rejected.
		add_row(1'b0, "o", 1'b0);
		add_row(1'b0, "n", 1'b0);
		add_row(1'b0, ",", 1'b0);
		add_row(1'b0, "0", 1'b0);
		add_row(1'b0, "s", 1'b1, 1'b1, {1'b0, 16'd0, 1'b1, 1'b1});
		// Minutes saturate at the top of the countdown.
		add_row(1'b0, "o", 1'b0);
		add_row(1'b0, "f", 1'b0);
		add_row(1'b0, "f", 1'b0);
		add_row(1'b0, ",", 1'b0);
		add_row(1'b0, "9", 1'b0);
		add_row(1'b0, "9", 1'b0);
		add_row(1'b0, "9", 1'b0);
		add_row(1'b0, "9", 1'b0);
		add_row(1'b0, "m", 1'b1, 1'b1, {1'b0, 16'hFFFF, 1'b1, 1'b0});
		add_row(1'b1, 8'hFF, 1'b1, 1'b1, {1'b0, 16'hFFFE, 1'b0, 1'b0});
		// A tick in the middle of text, then a bad byte.
		add_row(1'b0, "o", 1'b0);
		add_row(1'b1, 8'h00, 1'b0);
		add_row(1'b0, "n", 1'b0);
		add_row(1'b0, 8'hFF, 1'b1);

		for (int i = 0; i < directed_rows.size(); i++)
			send_word(directed_rows[i].tick, directed_rows[i].c, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].want);

		while (n_sent < directed_rows.size() + RANDOM_WORDS)
			send_random_command();
		in_valid <= 1'b0;

		while (status_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d words: %0d ticks and %0d commands, %0d of them rejected",
			n_sent, n_ticks, n_commands, n_rejected);
		$display("%0d timeouts ran out, %0d result words checked", n_expired, n_results);
		if (n_errors == 0)
			$display("timed_relay_command_parser: match");
		else
			$display("timed_relay_command_parser: mismatch");
		$finish;
	end

endmodule
